// ===== design/bgr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types and constants for the button gesture RGB LED controller.
// ----------------------------------------------------------------------------
package bgr_pkg;

	// width of each configuration register
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF   = 2'd2;

	// configuration reset values
	localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;
	localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd300;
	localparam logic [CFG_W-1:0] BLINK_HALF_RST   = 16'd500;

	// gesture codes
	typedef enum logic [1:0] {
		GEST_NONE   = 2'd0,
		GEST_CLICK  = 2'd1,
		GEST_DOUBLE = 2'd2,
		GEST_LONG   = 2'd3
	} gesture_t;

	// color codes
	localparam logic [1:0] COLOR_RED   = 2'd0;
	localparam logic [1:0] COLOR_GREEN = 2'd1;
	localparam logic [1:0] COLOR_BLUE  = 2'd2;
	localparam logic [1:0] COLOR_WHITE = 2'd3;

endpackage

// ===== design/bgr_gesture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_gesture
// Click, double click and long press classifier. Holds the press and
// release-window counters and reports the gesture of the tick being stepped.
// ----------------------------------------------------------------------------
module bgr_gesture
	import bgr_pkg::*;
#(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             level,
	input  logic [CFG_W-1:0] long_press_ticks,
	input  logic [CFG_W-1:0] double_click_ticks,
	output gesture_t         gesture
);

	localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

	logic [COUNTER_WIDTH-1:0] press_count_q;
	logic [COUNTER_WIDTH-1:0] since_release_q;
	logic                     long_seen_q;
	logic                     pending_q;
	logic                     prev_level_q;

	logic [COUNTER_WIDTH-1:0] press_count_d;
	logic [COUNTER_WIDTH-1:0] since_release_d;
	logic [COUNTER_WIDTH-1:0] press_inc;
	logic [COUNTER_WIDTH-1:0] since_inc;
	logic                     long_seen_d;
	logic                     pending_d;
	logic                     release_edge;
	gesture_t                 gest_d;

	assign press_inc    = press_count_q + 1'b1;
	assign release_edge = prev_level_q & ~level;

	// next state of the classifier for one tick
	always_comb begin
		press_count_d   = press_count_q;
		since_release_d = since_release_q;
		long_seen_d     = long_seen_q;
		pending_d       = pending_q;
		gest_d          = GEST_NONE;
		since_inc       = '0;

		// held: count toward a long press, repeat every period
		if (level) begin
			press_count_d = press_inc;
			if (CMP_W'(press_inc) >= CMP_W'(long_press_ticks)) begin
				long_seen_d   = 1'b1;
				gest_d        = GEST_LONG;
				press_count_d = '0;
			end
		end

		// release: second one inside the window is a double click
		if (release_edge) begin
			press_count_d = '0;
			if (!long_seen_q) begin
				if (pending_q) begin
					gest_d          = GEST_DOUBLE;
					pending_d       = 1'b0;
					since_release_d = '0;
				end else begin
					pending_d = 1'b1;
				end
			end else begin
				long_seen_d = 1'b0;
			end
		end

		// window expiry after a single release is a click
		if (pending_d) begin
			since_inc       = since_release_d + 1'b1;
			since_release_d = since_inc;
			if (CMP_W'(since_inc) >= CMP_W'(double_click_ticks)) begin
				gest_d          = GEST_CLICK;
				pending_d       = 1'b0;
				since_release_d = '0;
			end
		end
	end

	assign gesture = gest_d;

	// classifier state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_count_q   <= '0;
			since_release_q <= '0;
			long_seen_q     <= 1'b0;
			pending_q       <= 1'b0;
			prev_level_q    <= 1'b0;
		end else if (step) begin
			press_count_q   <= press_count_d;
			since_release_q <= since_release_d;
			long_seen_q     <= long_seen_d;
			pending_q       <= pending_d;
			prev_level_q    <= level;
		end
	end

endmodule

// ===== design/button_gesture_rgb_led_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_rgb_led_control
// Button gesture detector driving the three pins of an RGB LED.
// ----------------------------------------------------------------------------
// Each input word is one tick of the sampled button level; each tick gives
// one result word with the gesture seen on that tick and the red, green and
// blue pin levels after it was applied. A long press toggles the LED; with the
// LED on, a click steps the color red, green, blue, white, and a double click
// turns on blinking. The block takes one word per clock cycle when the result
// side does not stall; a word is held in the input register, and its result is
// computed as it leaves and held in the result register. The input register
// only advances when the result register is empty or being taken.
// Configuration writes are always ready and take effect on the next tick.
// ----------------------------------------------------------------------------
module button_gesture_rgb_led_control
	import bgr_pkg::*;
#(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 button_level,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           gesture,
	output logic                 red_on,
	output logic                 green_on,
	output logic                 blue_on
);

	localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

	logic [CFG_W-1:0] long_press_q;
	logic [CFG_W-1:0] double_click_q;
	logic [CFG_W-1:0] blink_half_q;

	logic valid_s1;
	logic level_s1;
	logic advance;

	logic                     led_en_q;
	logic [1:0]               color_q;
	logic                     blink_mode_q;
	logic [COUNTER_WIDTH-1:0] blink_count_q;
	logic                     blink_phase_q;

	logic                     led_en_d;
	logic [1:0]               color_d;
	logic                     blink_mode_d;
	logic [COUNTER_WIDTH-1:0] blink_count_d;
	logic [COUNTER_WIDTH-1:0] blink_inc;
	logic                     blink_phase_d;
	logic                     lit;
	gesture_t                 gest;

	logic       out_valid_q;
	logic [1:0] gesture_q;
	logic       red_q;
	logic       green_q;
	logic       blue_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q   <= LONG_PRESS_RST;
			double_click_q <= DOUBLE_CLICK_RST;
			blink_half_q   <= BLINK_HALF_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LONG_PRESS:   long_press_q   <= cfg_data;
				CFG_DOUBLE_CLICK: double_click_q <= cfg_data;
				CFG_BLINK_HALF:   blink_half_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: input register advances when the result register frees up
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= button_level;
		end
	end

	// gesture classifier
	bgr_gesture #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_gesture (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (advance),
		.level             (level_s1),
		.long_press_ticks  (long_press_q),
		.double_click_ticks(double_click_q),
		.gesture           (gest)
	);

	// gesture handling and blink divider
	assign blink_inc = blink_count_q + 1'b1;

	always_comb begin
		led_en_d     = led_en_q;
		color_d      = color_q;
		blink_mode_d = blink_mode_q;
		case (gest)
			GEST_CLICK: begin
				blink_mode_d = 1'b0;
				if (led_en_q) begin
					color_d = color_q + 1'b1;
				end
			end
			GEST_DOUBLE: begin
				if (led_en_q) begin
					blink_mode_d = 1'b1;
				end
			end
			GEST_LONG: begin
				blink_mode_d = 1'b0;
				led_en_d     = ~led_en_q;
			end
			default: ;
		endcase

		blink_count_d = blink_inc;
		blink_phase_d = blink_phase_q;
		if (CMP_W'(blink_inc) >= CMP_W'(blink_half_q)) begin
			blink_count_d = '0;
			blink_phase_d = ~blink_phase_q;
		end
	end

	assign lit = led_en_d & ~(blink_mode_d & blink_phase_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_en_q      <= 1'b0;
			color_q       <= COLOR_RED;
			blink_mode_q  <= 1'b0;
			blink_count_q <= '0;
			blink_phase_q <= 1'b0;
		end else if (advance) begin
			led_en_q      <= led_en_d;
			color_q       <= color_d;
			blink_mode_q  <= blink_mode_d;
			blink_count_q <= blink_count_d;
			blink_phase_q <= blink_phase_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_q <= gest;
			red_q     <= lit & (color_d == COLOR_RED   || color_d == COLOR_WHITE);
			green_q   <= lit & (color_d == COLOR_GREEN || color_d == COLOR_WHITE);
			blue_q    <= lit & (color_d == COLOR_BLUE  || color_d == COLOR_WHITE);
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;
	assign red_on    = red_q;
	assign green_on  = green_q;
	assign blue_on   = blue_q;

endmodule

// ===== bench/button_gesture_rgb_led_control_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_rgb_led_control_test
// Self-checking bench for the button gesture RGB LED controller.
// ----------------------------------------------------------------------------
// Ticks of button level are pushed through the input channel. Each accepted
// word is run through a local model of the gesture detector, LED state and
// blink divider, and the predicted gesture and pin levels are queued. Every
// result word is checked field by field against the oldest prediction.
// Timing registers are rewritten between phases once the block has drained,
// covering zero, small, default and full-scale settings. Both channels stall
// at random, with one steady phase, a long hold on the result side and a
// sender pause until every result has come back.
// ----------------------------------------------------------------------------
module button_gesture_rgb_led_control_test;
	import bgr_pkg::*;

	localparam int CNT_W         = 16;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 2000;
	localparam int IDLE_PCT      = 38;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_TICKS   = 160;
	localparam int NUM_PHASES    = 6;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		gesture_t gest;
		logic     red;
		logic     green;
		logic     blue;
	} led_word_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 button_level;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           gesture;
	logic                 red_on;
	logic                 green_on;
	logic                 blue_on;

	// model copy of the timing registers
	logic [CFG_W-1:0] long_ticks;
	logic [CFG_W-1:0] dbl_ticks;
	logic [CFG_W-1:0] blink_ticks;
	// model copy of the detector and LED state
	logic [CNT_W-1:0] press_cnt;
	logic [CNT_W-1:0] release_cnt;
	logic [CNT_W-1:0] blink_cnt;
	logic             held_long;
	logic             click_pending;
	logic             last_level;
	logic             led_on;
	logic             blink_on;
	logic             blink_phase;
	logic [1:0]       color;

	led_word_t led_expect_q[$];

	int errors        = 0;
	int ticks_sent    = 0;
	int words_checked = 0;
	int clicks_seen   = 0;
	int doubles_seen  = 0;
	int longs_seen    = 0;
	int settings_used = 0;
	int idle_cycles   = 0;
	int rx_hold_len   = 0;
	bit steady        = 1'b0;

	button_gesture_rgb_led_control #(
		.COUNTER_WIDTH(CNT_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.button_level(button_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.gesture     (gesture),
		.red_on      (red_on),
		.green_on    (green_on),
		.blue_on     (blue_on)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one tick of the gesture detector, LED state and blink divider
	function automatic led_word_t predict_tick(input logic level);
		gesture_t  ev;
		logic      lit;
		led_word_t r;
		ev = GEST_NONE;
		// hold timer, repeats while held
		if (level) begin
			press_cnt = press_cnt + 1'b1;
			if (press_cnt >= long_ticks) begin
				held_long = 1'b1;
				ev = GEST_LONG;
				press_cnt = '0;
			end
		end
		// release edge
		if (last_level && !level) begin
			press_cnt = '0;
			if (!held_long) begin
				if (click_pending) begin
					ev = GEST_DOUBLE;
					click_pending = 1'b0;
					release_cnt = '0;
				end else begin
					click_pending = 1'b1;
				end
			end else begin
				held_long = 1'b0;
			end
		end
		last_level = level;
		// click window, counts on the release tick too and beats a long press
		if (click_pending) begin
			release_cnt = release_cnt + 1'b1;
			if (release_cnt >= dbl_ticks) begin
				ev = GEST_CLICK;
				click_pending = 1'b0;
				release_cnt = '0;
			end
		end
		// apply gesture
		case (ev)
			GEST_CLICK: begin
				blink_on = 1'b0;
				if (led_on)
					color = color + 2'd1;
			end
			GEST_DOUBLE: begin
				if (led_on)
					blink_on = 1'b1;
			end
			GEST_LONG: begin
				blink_on = 1'b0;
				led_on = !led_on;
			end
			default: ;
		endcase
		// blink divider
		blink_cnt = blink_cnt + 1'b1;
		if (blink_cnt >= blink_ticks) begin
			blink_cnt = '0;
			blink_phase = !blink_phase;
		end
		// pin drive
		lit = led_on && !(blink_on && blink_phase);
		r.gest  = ev;
		r.red   = lit && (color == COLOR_RED || color == COLOR_WHITE);
		r.green = lit && (color == COLOR_GREEN || color == COLOR_WHITE);
		r.blue  = lit && (color == COLOR_BLUE || color == COLOR_WHITE);
		return r;
	endfunction

	function void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		led_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (led_expect_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, expected none, got gesture %0d",
					$time, gesture);
			end else begin
				exp_w = led_expect_q.pop_front();
				check_field("gesture", int'(exp_w.gest), int'(gesture));
				check_field("red_on", int'(exp_w.red), int'(red_on));
				check_field("green_on", int'(exp_w.green), int'(green_on));
				check_field("blue_on", int'(exp_w.blue), int'(blue_on));
				words_checked++;
				case (exp_w.gest)
					GEST_CLICK:  clicks_seen++;
					GEST_DOUBLE: doubles_seen++;
					GEST_LONG:   longs_seen++;
					default: ;
				endcase
			end
		end
	end

	// result side ready, with random stalls and an occasional long hold
	always @(posedge clk) begin
		if (rx_hold_len > 0) begin
			out_ready <= 1'b0;
			rx_hold_len = rx_hold_len - 1;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, led_expect_q.size());
				$display("button_gesture_rgb_led_control_test: done, errors");
				$finish;
			end
		end
	end

	// send one tick, with a random gap before it
	task automatic send_tick(input logic level);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		button_level <= level;
		do @(posedge clk); while (!in_ready);
		led_expect_q.push_back(predict_tick(level));
		ticks_sent++;
	endtask

	task automatic send_run(input logic level, input int n);
		repeat (n) send_tick(level);
	endtask

	// stop sending and wait for every result, then let the pipeline settle
	task automatic quiesce();
		in_valid <= 1'b0;
		while (led_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LONG_PRESS:   long_ticks  = val;
			CFG_DOUBLE_CLICK: dbl_ticks   = val;
			CFG_BLINK_HALF:   blink_ticks = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] dc,
			input logic [CFG_W-1:0] bh);
		quiesce();
		write_reg(CFG_LONG_PRESS, lp);
		write_reg(CFG_DOUBLE_CLICK, dc);
		write_reg(CFG_BLINK_HALF, bh);
		settings_used++;
	endtask

	// one random button gesture shaped by the current timing
	task automatic gesture_burst();
		int unsigned lp;
		int unsigned dp;
		int unsigned pick;
		lp = (long_ticks > 40) ? 40 : ((long_ticks == 0) ? 1 : long_ticks);
		dp = (dbl_ticks > 30) ? 30 : ((dbl_ticks == 0) ? 1 : dbl_ticks);
		pick = $urandom_range(99);
		if (pick < 28) begin
			// single click, then let the window run out
			send_run(1'b1, $urandom_range(1, (lp > 1) ? lp - 1 : 1));
			send_run(1'b0, $urandom_range(dp, dp + 2));
		end else if (pick < 50) begin
			// double click
			send_run(1'b1, $urandom_range(1, (lp > 1) ? lp - 1 : 1));
			send_run(1'b0, $urandom_range(1, (dp > 1) ? dp - 1 : 1));
			send_run(1'b1, $urandom_range(1, (lp > 1) ? lp - 1 : 1));
			send_run(1'b0, $urandom_range(1, dp + 2));
		end else if (pick < 70) begin
			// long hold, may repeat
			send_run(1'b1, $urandom_range(lp, 3 * lp));
			send_run(1'b0, $urandom_range(1, 4));
		end else if (pick < 82) begin
			// press again right after a release, racing window against hold
			send_run(1'b1, $urandom_range(1, 3));
			send_run(1'b0, 1);
			send_run(1'b1, $urandom_range(1, lp + 2));
			send_run(1'b0, $urandom_range(1, 3));
		end else begin
			// noise
			repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(1)));
		end
	endtask

	task automatic bursts_until(input int target);
		while (ticks_sent < target)
			gesture_burst();
	endtask

	// hand-picked sequence through every gesture and corner
	task automatic test_directed();
		set_timing(16'd3, 16'd4, 16'd2);
		// hold to a long press, LED turns on
		send_run(1'b1, 3);
		// release after long press counts no click
		send_run(1'b0, 1);
		// first release opens the window
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		// window and hold expire together, click wins
		send_run(1'b1, 3);
		send_run(1'b0, 1);
		// double click starts blinking
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		// blink phase runs
		send_run(1'b0, 4);
		// click stops blinking and steps the color
		send_run(1'b1, 1);
		send_run(1'b0, 4);
	endtask

	// zero timing makes every compare fire; the unused index is ignored
	task automatic test_zero_registers();
		set_timing(16'd0, 16'd0, 16'd0);
		write_reg(CFG_UNUSED, 16'hffff);
		repeat (20) send_tick(1'($urandom_range(1)));
	endtask

	// full-scale timing
	task automatic test_extremes();
		set_timing(16'hffff, 16'hffff, 16'hffff);
		write_reg(CFG_UNUSED, 16'h0000);
		send_run(1'b1, 20);
		repeat (20) send_tick(1'($urandom_range(1)));
	endtask

	// phases of random gestures under several timings
	task automatic test_random();
		int phase_end;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: set_timing(16'd1, 16'd1, 16'd1);
				1: set_timing(16'd2, 16'd3, 16'd1);
				2: set_timing(16'd5, 16'd8, 16'd3);
				3: set_timing(16'd12, 16'd20, 16'd7);
				4: set_timing(LONG_PRESS_RST, DOUBLE_CLICK_RST, BLINK_HALF_RST);
				default: set_timing(CFG_W'($urandom_range(1, 16)),
					CFG_W'($urandom_range(1, 24)), CFG_W'($urandom_range(1, 12)));
			endcase
			// one phase runs with no idling on either side
			steady = (p == 2);
			phase_end = ticks_sent + PHASE_TICKS;
			bursts_until(phase_end);
		end
		steady = 1'b0;
	endtask

	// long hold on results while ticks keep coming, then a full drain
	task automatic test_backpressure();
		set_timing(16'd3, 16'd5, 16'd2);
		rx_hold_len = HOLD_CYCLES;
		bursts_until(ticks_sent + 60);
		quiesce();
		bursts_until(ticks_sent + 40);
	endtask

	initial begin
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_LONG_PRESS;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		button_level <= 1'b0;
		long_ticks    = LONG_PRESS_RST;
		dbl_ticks     = DOUBLE_CLICK_RST;
		blink_ticks   = BLINK_HALF_RST;
		press_cnt     = '0;
		release_cnt   = '0;
		blink_cnt     = '0;
		held_long     = 1'b0;
		click_pending = 1'b0;
		last_level    = 1'b0;
		led_on        = 1'b0;
		blink_on      = 1'b0;
		blink_phase   = 1'b0;
		color         = COLOR_RED;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_zero_registers();
		test_extremes();
		test_random();
		test_backpressure();
		quiesce();

		$display("covered %0d ticks under %0d timing settings, %0d results checked",
			ticks_sent, settings_used, words_checked);
		$display("gestures seen: %0d clicks, %0d double clicks, %0d long presses",
			clicks_seen, doubles_seen, longs_seen);
		if (errors == 0)
			$display("button_gesture_rgb_led_control_test: done, clean");
		else
			$display("button_gesture_rgb_led_control_test: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
design/bgr_pkg.sv
design/bgr_gesture.sv
design/button_gesture_rgb_led_control.sv
bench/button_gesture_rgb_led_control_test.sv
